>>> hdl/dbsd_pkg.sv
`default_nettype none
package dbsd_pkg;

   // default geometry
   localparam int ROI_PIXELS_DEF  = 4096;
   localparam int INIT_FRAMES_DEF = 10;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_NOISE_THRESHOLD   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTER_COUNT       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEAVE_COUNT       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BUBBLE_MIN_LEVEL  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BUBBLE_MAX_SPREAD = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_UPDATE_INTERVAL   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_UPDATE_MAX_NOISE  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_UPDATE_ALPHA      = 3'd7;

   // register reset values
   localparam logic [7:0]  RST_NOISE_THRESHOLD   = 8'd30;
   localparam logic [15:0] RST_ENTER_COUNT       = 16'd80;
   localparam logic [15:0] RST_LEAVE_COUNT       = 16'd20;
   localparam logic [7:0]  RST_BUBBLE_MIN_LEVEL  = 8'd220;
   localparam logic [7:0]  RST_BUBBLE_MAX_SPREAD = 8'd25;
   localparam logic [15:0] RST_UPDATE_INTERVAL   = 16'd300;
   localparam logic [15:0] RST_UPDATE_MAX_NOISE  = 16'd10;
   localparam logic [8:0]  RST_UPDATE_ALPHA      = 9'd13;

   // frame kinds
   localparam logic [1:0] KIND_INIT     = 2'd0;
   localparam logic [1:0] KIND_IDLE     = 2'd1;
   localparam logic [1:0] KIND_SAMPLING = 2'd2;
   localparam logic [1:0] KIND_REPORT   = 2'd3;

   // fixed widths
   localparam int COUNT_W = 13;
   localparam int MATH_W  = 64;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PIX,
      ST_EOF,
      ST_PASS_RD,
      ST_PASS_CH,
      ST_PASS_WR,
      ST_MATH_GO,
      ST_MATH_WAIT,
      ST_ACC,
      ST_FIN
   } state_type;

   typedef enum logic [2:0] {
      MOP_RATIO,
      MOP_MEAN,
      MOP_NSQ,
      MOP_MAGSQ,
      MOP_NN,
      MOP_VAR
   } mop_type;

   typedef struct packed {
      logic       accept;
      logic       pix;
      logic       commit;
      logic       pass_rd;
      logic       pass_ch;
      logic [1:0] ch;
      logic       pass_wr;
      logic       math_start;
      logic       math_capture;
      mop_type    op;
      logic       acc;
      logic       fin;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic need_avg;
      logic need_blend;
      logic need_ratio;
      logic need_report;
      logic pass_end;
      logic math_done;
      logic var_pos;
      logic out_free;
   } stat_type;

endpackage
`default_nettype wire

>>> hdl/dbsd_muldiv.sv
`default_nettype none
// shared bit-serial multiplier / restoring divider
module dbsd_muldiv
   import dbsd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic              op_div,
   input  wire logic [MATH_W-1:0] a,
   input  wire logic [MATH_W-1:0] b,
   output logic                   done,
   output logic [MATH_W-1:0]      result
);

   localparam logic [6:0] MUL_LAST = 7'd31;
   localparam logic [6:0] DIV_LAST = 7'(MATH_W - 1);

   logic              busy_ff, done_ff, div_ff;
   logic [6:0]        cnt_ff;
   logic [MATH_W-1:0] acc_ff, x_ff, y_ff;
   logic [MATH_W:0]   rem_ff;
   logic [MATH_W:0]   rem_sh;

   assign rem_sh = {rem_ff[MATH_W-1:0], x_ff[MATH_W-1]};

   // one multiplier bit or one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            div_ff  <= op_div;
            acc_ff  <= '0;
            rem_ff  <= '0;
            x_ff    <= a;
            y_ff    <= b;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 7'd1;
            x_ff   <= x_ff << 1;
            if (div_ff) begin
               if (rem_sh >= {1'b0, y_ff}) begin
                  rem_ff <= rem_sh - {1'b0, y_ff};
                  acc_ff <= {acc_ff[MATH_W-2:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh;
                  acc_ff <= {acc_ff[MATH_W-2:0], 1'b0};
               end
            end else begin
               y_ff <= y_ff >> 1;
               if (y_ff[0]) begin
                  acc_ff <= acc_ff + x_ff;
               end
            end
            if (cnt_ff == (div_ff ? DIV_LAST : MUL_LAST)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done   = done_ff;
   assign result = acc_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset) start |-> !busy_ff)
      else $error("muldiv started while busy");

endmodule
`default_nettype wire

>>> hdl/dbsd_ctrl.sv
`default_nettype none
// frame sequencer: pixel handshake, end-of-frame passes and math steps
module dbsd_ctrl
   import dbsd_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_tvalid,
   output logic          req_tready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   state_type state_ff, state_in;
   mop_type   op_ff, op_in;
   logic [1:0] ch_ff, ch_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= MOP_RATIO;
         ch_ff    <= 2'd0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         ch_ff    <= ch_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      ch_in      = ch_ff;
      cmd        = '0;
      cmd.op     = op_ff;
      cmd.ch     = ch_ff;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_PIX;
            end
         end
         ST_PIX: begin
            cmd.pix  = 1'b1;
            state_in = stat.last ? ST_EOF : ST_IDLE;
         end
         ST_EOF: begin
            cmd.commit = 1'b1;
            if (stat.need_avg || stat.need_blend) begin
               state_in = ST_PASS_RD;
            end else if (stat.need_ratio) begin
               op_in    = MOP_RATIO;
               state_in = ST_MATH_GO;
            end else if (stat.need_report) begin
               op_in    = MOP_MEAN;
               state_in = ST_MATH_GO;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_PASS_RD: begin
            cmd.pass_rd = 1'b1;
            ch_in       = 2'd0;
            state_in    = ST_PASS_CH;
         end
         ST_PASS_CH: begin
            cmd.pass_ch = 1'b1;
            if (ch_ff == 2'd2) begin
               state_in = ST_PASS_WR;
            end else begin
               ch_in = ch_ff + 2'd1;
            end
         end
         ST_PASS_WR: begin
            cmd.pass_wr = 1'b1;
            state_in    = stat.pass_end ? ST_FIN : ST_PASS_RD;
         end
         ST_MATH_GO: begin
            cmd.math_start = 1'b1;
            state_in       = ST_MATH_WAIT;
         end
         ST_MATH_WAIT: begin
            if (stat.math_done) begin
               cmd.math_capture = 1'b1;
               case (op_ff)
                  MOP_RATIO: state_in = ST_ACC;
                  MOP_MEAN: begin
                     op_in    = MOP_NSQ;
                     state_in = ST_MATH_GO;
                  end
                  MOP_NSQ: begin
                     op_in    = MOP_MAGSQ;
                     state_in = ST_MATH_GO;
                  end
                  MOP_MAGSQ: begin
                     op_in    = MOP_NN;
                     state_in = ST_MATH_GO;
                  end
                  MOP_NN: begin
                     if (stat.var_pos) begin
                        op_in    = MOP_VAR;
                        state_in = ST_MATH_GO;
                     end else begin
                        state_in = ST_FIN;
                     end
                  end
                  default: state_in = ST_FIN;
               endcase
            end
         end
         ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (stat.out_free) begin
               cmd.fin  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_accept_pix: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> state_ff == ST_PIX)
      else $error("accepted word not processed next cycle");

   a_fin_free: assert property (@(posedge clock) disable iff (reset)
      cmd.fin |-> stat.out_free)
      else $error("result loaded over a pending word");

endmodule
`default_nettype wire

>>> hdl/dbsd_datapath.sv
`default_nettype none
// pixel datapath, stores, droplet statistics and result register
module dbsd_datapath
   import dbsd_pkg::*;
#(
   parameter int ROI_PIXELS  = ROI_PIXELS_DEF,
   parameter int INIT_FRAMES = INIT_FRAMES_DEF
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic [23:0]           req_pixel,
   input  wire logic                  req_last,
   input  wire logic                  req_restart,
   input  wire cmd_type               cmd,
   output stat_type                   stat,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [1:0]                 rsp_kind,
   output logic [COUNT_W-1:0]         rsp_count,
   output logic [15:0]                rsp_frames,
   output logic [15:0]                rsp_mean,
   output logic [14:0]                rsp_var,
   output logic                       rsp_updated
);

   localparam int AW = $clog2(ROI_PIXELS);
   localparam int PW = $clog2(ROI_PIXELS + 1);
   localparam logic [PW-1:0] ROI_P = PW'(ROI_PIXELS);
   localparam int RSH = 24;
   localparam longint RECIP_L = ((64'd1 << RSH) + INIT_FRAMES - 1) / INIT_FRAMES;
   localparam logic [24:0] RECIP = 25'(RECIP_L);
   localparam logic [12:0] HALF_N = 13'(INIT_FRAMES / 2);
   localparam logic [3:0] INIT_N = 4'(INIT_FRAMES);

   // configuration registers
   logic [7:0]  thr_ff, bmin_ff, bspread_ff;
   logic [15:0] enter_ff, leave_ff, interval_ff, maxnoise_ff;
   logic [8:0]  alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff      <= RST_NOISE_THRESHOLD;
         enter_ff    <= RST_ENTER_COUNT;
         leave_ff    <= RST_LEAVE_COUNT;
         bmin_ff     <= RST_BUBBLE_MIN_LEVEL;
         bspread_ff  <= RST_BUBBLE_MAX_SPREAD;
         interval_ff <= RST_UPDATE_INTERVAL;
         maxnoise_ff <= RST_UPDATE_MAX_NOISE;
         alpha_ff    <= RST_UPDATE_ALPHA;
      end else if (csr_we) begin
         case (csr_index)
            CSR_NOISE_THRESHOLD:   thr_ff      <= csr_wdata[7:0];
            CSR_ENTER_COUNT:       enter_ff    <= csr_wdata;
            CSR_LEAVE_COUNT:       leave_ff    <= csr_wdata;
            CSR_BUBBLE_MIN_LEVEL:  bmin_ff     <= csr_wdata[7:0];
            CSR_BUBBLE_MAX_SPREAD: bspread_ff  <= csr_wdata[7:0];
            CSR_UPDATE_INTERVAL:   interval_ff <= csr_wdata;
            CSR_UPDATE_MAX_NOISE:  maxnoise_ff <= csr_wdata;
            CSR_UPDATE_ALPHA:      alpha_ff    <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   // stores
   logic [23:0] bg_mem [ROI_PIXELS];
   logic [35:0] fs_mem [ROI_PIXELS];
   logic [23:0] bg_q;
   logic [35:0] fs_q;
   logic        rd_en, fs_we;
   logic [AW-1:0] rd_addr;
   logic [35:0] fs_wdata;

   // state
   logic [23:0]   px_ff;
   logic          last_ff, in_roi_ff;
   logic [PW-1:0] pos_ff, len_ff;
   logic [AW-1:0] idx_ff;
   logic          ready_ff, sampling_ff, blend_ff;
   logic [3:0]    init_seen_ff;
   logic [15:0]   fsu_ff, sampled_ff;
   logic signed [31:0] rsum_ff;
   logic [47:0]   sqsum_ff;
   logic [COUNT_W-1:0] mcount_ff;
   logic [19:0]   mred_ff, mblue_ff;
   logic [23:0]   nv_ff;
   logic signed [15:0] c_ff;
   logic [MATH_W-1:0] p1_ff, p2_ff;
   logic [31:0]   d_ff;
   // result staging and output register
   logic [1:0]    res_kind_ff;
   logic [COUNT_W-1:0] res_count_ff;
   logic [15:0]   res_frames_ff, res_mean_ff;
   logic [14:0]   res_var_ff;
   logic          res_upd_ff;
   logic          rsp_valid_ff;
   logic [1:0]    rsp_kind_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic [15:0]   rsp_frames_ff, rsp_mean_ff;
   logic [14:0]   rsp_var_ff;
   logic          rsp_upd_ff;

   // memory ports
   assign rd_en   = cmd.accept || cmd.pass_rd;
   assign rd_addr = cmd.accept ? pos_ff[AW-1:0] : idx_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         bg_q <= bg_mem[rd_addr];
         fs_q <= fs_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (fs_we) begin
         fs_mem[pos_ff[AW-1:0]] <= fs_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pass_wr) begin
         bg_mem[idx_ff] <= nv_ff;
      end
   end

   // per-pixel compare against the background
   logic [7:0]  pr, pg, pb, dr, dg, db, mx, mn;
   logic [15:0] gsum;
   logic        bubble, fg;
   logic [20:0] red_add, blue_add;
   logic [35:0] acc_in, acc_sum;

   assign pr = px_ff[7:0];
   assign pg = px_ff[15:8];
   assign pb = px_ff[23:16];
   assign dr = (pr > bg_q[7:0])   ? pr - bg_q[7:0]   : bg_q[7:0]   - pr;
   assign dg = (pg > bg_q[15:8])  ? pg - bg_q[15:8]  : bg_q[15:8]  - pg;
   assign db = (pb > bg_q[23:16]) ? pb - bg_q[23:16] : bg_q[23:16] - pb;
   assign gsum = 16'(dr) * 16'd77 + 16'(dg) * 16'd150 + 16'(db) * 16'd29 + 16'd128;

   always_comb begin
      mx = pr;
      mn = pr;
      if (pg > mx) mx = pg;
      if (pb > mx) mx = pb;
      if (pg < mn) mn = pg;
      if (pb < mn) mn = pb;
   end

   assign bubble   = (mn >= bmin_ff) && ((mx - mn) <= bspread_ff);
   assign fg       = (gsum[15:8] > thr_ff) && !bubble;
   assign red_add  = 21'(mred_ff) + 21'(pr);
   assign blue_add = 21'(mblue_ff) + 21'(pb);

   // init accumulation, 12 bits per channel, saturating
   assign acc_in = (init_seen_ff == 4'd0) ? 36'd0 : fs_q;
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         logic [12:0] s;
         s = 13'(acc_in[12*k +: 12]) + 13'(px_ff[8*k +: 8]);
         acc_sum[12*k +: 12] = s[12] ? 12'hFFF : s[11:0];
      end
   end

   assign fs_we    = cmd.pix && in_roi_ff;
   assign fs_wdata = ready_ff ? {12'd0, px_ff} : acc_sum;

   // end-of-frame plan
   logic [3:0]  init_next;
   logic        init_done, start_drop, keep_samp, samp_full, need_blend;
   logic [15:0] fsu_next;
   logic [1:0]  kind;

   assign init_next  = init_seen_ff + 4'd1;
   assign init_done  = init_next >= INIT_N;
   assign fsu_next   = (fsu_ff == 16'hFFFF) ? fsu_ff : fsu_ff + 16'd1;
   assign start_drop = ready_ff && !sampling_ff && (16'(mcount_ff) >= enter_ff);
   assign need_blend = ready_ff && !sampling_ff && !start_drop
                       && (fsu_next >= interval_ff) && (16'(mcount_ff) <= maxnoise_ff);
   assign keep_samp  = ready_ff && sampling_ff && (16'(mcount_ff) > leave_ff);
   assign samp_full  = sampled_ff == 16'hFFFF;

   always_comb begin
      if (!ready_ff) begin
         kind = KIND_INIT;
      end else if (!sampling_ff) begin
         kind = start_drop ? KIND_SAMPLING : KIND_IDLE;
      end else if (keep_samp) begin
         kind = KIND_SAMPLING;
      end else if (sampled_ff == 16'd0) begin
         kind = KIND_IDLE;
      end else begin
         kind = KIND_REPORT;
      end
   end

   // per-channel pass arithmetic: init average or background blend
   logic [11:0] avg_s;
   logic [12:0] avg_x;
   logic [37:0] avg_p;
   logic [12:0] avg_q;
   logic [7:0]  avg_v, blend_v, ch_v;
   logic [8:0]  alpha_c;
   logic signed [8:0]  bl_diff;
   logic signed [18:0] bl_prod, bl_sum;

   assign avg_s   = fs_q[12*cmd.ch +: 12];
   assign avg_x   = 13'(avg_s) + HALF_N;
   assign avg_p   = 38'(avg_x) * 38'(RECIP);
   assign avg_q   = avg_p[RSH +: 13];
   assign avg_v   = (avg_q > 13'd255) ? 8'hFF : avg_q[7:0];
   assign alpha_c = (alpha_ff > 9'd256) ? 9'd256 : alpha_ff;
   assign bl_diff = $signed({1'b0, fs_q[8*cmd.ch +: 8]}) - $signed({1'b0, bg_q[8*cmd.ch +: 8]});
   assign bl_prod = 19'($signed({1'b0, alpha_c}) * bl_diff);
   assign bl_sum  = $signed({3'b0, bg_q[8*cmd.ch +: 8], 8'h80}) + bl_prod;
   assign blend_v = bl_sum[15:8];
   assign ch_v    = blend_ff ? blend_v : avg_v;

   // math operands
   logic [20:0] rb_den;
   logic [19:0] rb_diff;
   logic [31:0] mag;
   logic [MATH_W-1:0] var_den, var_num, m_a, m_b, m_res;
   logic        m_div, m_done;

   assign rb_den  = 21'(mred_ff) + 21'(mblue_ff);
   assign rb_diff = (mred_ff >= mblue_ff) ? mred_ff - mblue_ff : mblue_ff - mred_ff;
   assign mag     = rsum_ff[31] ? 32'(-rsum_ff) : 32'(rsum_ff);
   assign var_den = MATH_W'(d_ff) << 15;
   assign var_num = p1_ff - p2_ff;

   always_comb begin
      m_a   = '0;
      m_b   = '0;
      m_div = 1'b0;
      case (cmd.op)
         MOP_RATIO: begin
            m_a   = (MATH_W'(rb_diff) << 15) + MATH_W'(rb_den >> 1);
            m_b   = MATH_W'(rb_den);
            m_div = 1'b1;
         end
         MOP_MEAN: begin
            m_a   = MATH_W'(mag) + MATH_W'(sampled_ff >> 1);
            m_b   = MATH_W'(sampled_ff);
            m_div = 1'b1;
         end
         MOP_NSQ: begin
            m_a = MATH_W'(sqsum_ff);
            m_b = MATH_W'(sampled_ff);
         end
         MOP_MAGSQ: begin
            m_a = MATH_W'(mag);
            m_b = MATH_W'(mag);
         end
         MOP_NN: begin
            m_a = MATH_W'(sampled_ff);
            m_b = MATH_W'(sampled_ff);
         end
         MOP_VAR: begin
            m_a   = var_num + (var_den >> 1);
            m_b   = var_den;
            m_div = 1'b1;
         end
         default: ;
      endcase
   end

   dbsd_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.math_start),
      .op_div (m_div),
      .a      (m_a),
      .b      (m_b),
      .done   (m_done),
      .result (m_res)
   );

   // clamped results of the divisions
   logic signed [15:0] c_new, mean_new;
   logic [14:0] var_new;

   always_comb begin
      if (rb_den == 21'd0) begin
         c_new = 16'sd0;
      end else if (mred_ff >= mblue_ff) begin
         c_new = (m_res > 64'd32767) ? 16'sd32767 : $signed(m_res[15:0]);
      end else begin
         c_new = 16'(-$signed({1'b0, m_res[15:0]}));
      end
      if (!rsum_ff[31]) begin
         mean_new = (m_res > 64'd32767) ? 16'sd32767 : $signed(m_res[15:0]);
      end else begin
         mean_new = (m_res > 64'd32768) ? -16'sd32768 : 16'(-$signed({1'b0, m_res[15:0]}));
      end
      var_new = (m_res > 64'd32767) ? 15'h7FFF : m_res[14:0];
   end

   logic signed [31:0] c_sq;
   assign c_sq = c_ff * c_ff;

   // control state of the frame
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         ready_ff     <= 1'b0;
         init_seen_ff <= 4'd0;
         sampling_ff  <= 1'b0;
         fsu_ff       <= 16'd0;
         sampled_ff   <= 16'd0;
         rsum_ff      <= 32'sd0;
         sqsum_ff     <= 48'd0;
         mcount_ff    <= '0;
         mred_ff      <= 20'd0;
         mblue_ff     <= 20'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         // accept: latch the word; restart on a frame's first word if requested
         if (cmd.accept) begin
            px_ff     <= req_pixel;
            last_ff   <= req_last;
            in_roi_ff <= pos_ff < ROI_P;
            if (pos_ff == '0 && req_restart) begin
               ready_ff     <= 1'b0;
               init_seen_ff <= 4'd0;
               sampling_ff  <= 1'b0;
               sampled_ff   <= 16'd0;
               rsum_ff      <= 32'sd0;
               sqsum_ff     <= 48'd0;
            end
         end
         // pixel step
         if (cmd.pix) begin
            if (in_roi_ff) begin
               pos_ff <= pos_ff + PW'(1);
               if (ready_ff && fg) begin
                  if (mcount_ff != {COUNT_W{1'b1}}) begin
                     mcount_ff <= mcount_ff + COUNT_W'(1);
                  end
                  mred_ff  <= red_add[20]  ? 20'hFFFFF : red_add[19:0];
                  mblue_ff <= blue_add[20] ? 20'hFFFFF : blue_add[19:0];
               end
            end
            if (last_ff) begin
               pos_ff <= '0;
               len_ff <= in_roi_ff ? pos_ff + PW'(1) : ROI_P;
            end
         end
         // frame end decisions
         if (cmd.commit) begin
            res_kind_ff   <= kind;
            res_count_ff  <= ready_ff ? mcount_ff : '0;
            res_upd_ff    <= need_blend;
            res_frames_ff <= (kind == KIND_REPORT) ? sampled_ff : 16'd0;
            res_mean_ff   <= 16'd0;
            res_var_ff    <= 15'd0;
            blend_ff      <= need_blend;
            idx_ff        <= '0;
            if (!ready_ff) begin
               if (init_done) begin
                  ready_ff     <= 1'b1;
                  init_seen_ff <= 4'd0;
                  fsu_ff       <= 16'd0;
                  sampling_ff  <= 1'b0;
                  sampled_ff   <= 16'd0;
                  rsum_ff      <= 32'sd0;
                  sqsum_ff     <= 48'd0;
               end else begin
                  init_seen_ff <= init_next;
               end
            end else begin
               fsu_ff <= need_blend ? 16'd0 : fsu_next;
               if (start_drop) begin
                  sampling_ff <= 1'b1;
               end
               if (sampling_ff && !keep_samp && sampled_ff == 16'd0) begin
                  sampling_ff <= 1'b0;
               end
            end
         end
         // passes over the stores
         if (cmd.pass_ch) begin
            nv_ff[8*cmd.ch +: 8] <= ch_v;
         end
         if (cmd.pass_wr) begin
            idx_ff <= idx_ff + AW'(1);
         end
         // division and product results
         if (cmd.math_capture) begin
            case (cmd.op)
               MOP_RATIO: c_ff        <= c_new;
               MOP_MEAN:  res_mean_ff <= mean_new;
               MOP_NSQ:   p1_ff       <= m_res;
               MOP_MAGSQ: p2_ff       <= m_res;
               MOP_NN:    d_ff        <= m_res[31:0];
               MOP_VAR:   res_var_ff  <= var_new;
               default: ;
            endcase
         end
         // droplet accumulation
         if (cmd.acc) begin
            rsum_ff    <= rsum_ff + 32'(c_ff);
            sqsum_ff   <= sqsum_ff + 48'(c_sq);
            sampled_ff <= sampled_ff + 16'd1;
         end
         // hand the result to the output register
         if (cmd.fin) begin
            rsp_valid_ff  <= 1'b1;
            rsp_kind_ff   <= res_kind_ff;
            rsp_count_ff  <= res_count_ff;
            rsp_frames_ff <= res_frames_ff;
            rsp_mean_ff   <= res_mean_ff;
            rsp_var_ff    <= res_var_ff;
            rsp_upd_ff    <= res_upd_ff;
            mcount_ff     <= '0;
            mred_ff       <= 20'd0;
            mblue_ff      <= 20'd0;
            if (res_kind_ff == KIND_REPORT) begin
               sampling_ff <= 1'b0;
               sampled_ff  <= 16'd0;
               rsum_ff     <= 32'sd0;
               sqsum_ff    <= 48'd0;
            end
         end
      end
   end

   // status to the sequencer
   always_comb begin
      stat             = '0;
      stat.last        = last_ff;
      stat.need_avg    = !ready_ff && init_done;
      stat.need_blend  = need_blend;
      stat.need_ratio  = keep_samp && !samp_full;
      stat.need_report = kind == KIND_REPORT;
      stat.pass_end    = (PW'(idx_ff) + PW'(1)) == len_ff;
      stat.math_done   = m_done;
      stat.var_pos     = !var_num[MATH_W-1] && (var_num != '0);
      stat.out_free    = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_kind    = rsp_kind_ff;
   assign rsp_count   = rsp_count_ff;
   assign rsp_frames  = rsp_frames_ff;
   assign rsp_mean    = rsp_mean_ff;
   assign rsp_var     = rsp_var_ff;
   assign rsp_updated = rsp_upd_ff;

   a_pos_bound: assert property (@(posedge clock) disable iff (reset) pos_ff <= ROI_P)
      else $error("pixel position beyond ROI");

endmodule
`default_nettype wire

>>> hdl/droplet_background_subtraction_detector.sv
`default_nettype none
// Droplet detector by background subtraction.
// req channel: one ROI pixel per word in raster order; req_tlast marks the
// frame's last pixel, req_tuser requests a background restart on a frame's
// first pixel. rsp channel: one word per frame, issued after its last pixel.
// Pixel words are read from memory, then compared and stored, one at a time.
// Frame end: a decision step; an init-average or background-blend pass runs
// over each ROI pixel of the frame; a sampling frame may add one bit-serial
// division; a droplet report adds three products and one or two divisions
// on the shared bit-serial unit. The result sits in an output register; new
// pixels are taken while it waits, and only the next frame end holds if it
// is still not taken. After reset the first INIT_FRAMES frames build the
// background (kind 0); the stores need no clearing pass. Configuration is
// written through csr_*, one register per cycle; the user must write it only
// while the block is idle, which the block does not enforce.
module droplet_background_subtraction_detector
   import dbsd_pkg::*;
#(
   parameter int ROI_PIXELS  = ROI_PIXELS_DEF,
   parameter int INIT_FRAMES = INIT_FRAMES_DEF
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [23:0]           req_tdata,  // pixel_rgb
   input  wire logic                  req_tlast,  // last_pixel
   input  wire logic                  req_tuser,  // restart_background
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // foreground_count, droplet_frames, droplet_mean, droplet_variance,
   // background_updated, zero fill
   output logic [63:0]                rsp_tdata,
   output logic [1:0]                 rsp_tuser,  // frame_kind
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type  cmd;
   stat_type stat;
   logic [COUNT_W-1:0] rsp_count;
   logic [15:0] rsp_frames, rsp_mean;
   logic [14:0] rsp_var;
   logic        rsp_updated;

   dbsd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   dbsd_datapath #(
      .ROI_PIXELS  (ROI_PIXELS),
      .INIT_FRAMES (INIT_FRAMES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_pixel   (req_tdata),
      .req_last    (req_tlast),
      .req_restart (req_tuser),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_kind    (rsp_tuser),
      .rsp_count   (rsp_count),
      .rsp_frames  (rsp_frames),
      .rsp_mean    (rsp_mean),
      .rsp_var     (rsp_var),
      .rsp_updated (rsp_updated)
   );

   // pack the result word
   assign rsp_tdata = {3'd0, rsp_updated, rsp_var, rsp_mean, rsp_frames, rsp_count};

endmodule
`default_nettype wire

>>> tb/tb_droplet_background_subtraction_detector.sv
`default_nettype none
module tb_droplet_background_subtraction_detector;
   import dbsd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ROI   = ROI_PIXELS_DEF;
   localparam int NINIT = INIT_FRAMES_DEF;

   // kinds of generated frame content
   typedef enum int {FR_CLEAN, FR_DROPLET, FR_JUNK} scene_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [12:0] count;
      logic [15:0] frames;
      logic [15:0] mean;
      logic [14:0] variance;
      logic        updated;
   } frame_report_t;

   typedef struct {
      logic [23:0] pixel;
      bit          restart;
      bit          init_typed;
   } dir_row_t;

   logic                  clock = 0;
   logic                  reset;
   logic                  req_tvalid, req_tlast, req_tuser;
   logic [23:0]           req_tdata;
   logic                  req_tready;
   logic                  rsp_tvalid, rsp_tready;
   logic [63:0]           rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   droplet_background_subtraction_detector dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tlast(req_tlast), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   // ---------------- detector model ----------------
   int unsigned   thr, enter_lvl, leave_lvl, bub_min, bub_spread, upd_every, upd_noise, alpha;
   logic [23:0]   bg_mem [0:ROI-1];
   logic [35:0]   acc_mem [0:ROI-1];
   int unsigned   pix_pos, init_seen, since_upd, n_samples;
   bit            bg_ready, in_droplet;
   longint        c_sum;
   longint        c_sq_sum;
   int unsigned   fg_cnt, red_sum, blue_sum;
   frame_report_t expected_reports [$];
   int            errors = 0;
   int            items_sent = 0;

   task automatic clear_droplet();
      in_droplet = 0;
      n_samples  = 0;
      c_sum      = 0;
      c_sq_sum   = 0;
   endtask

   function automatic int absdiff(int a, int b);
      return a > b ? a - b : b - a;
   endfunction

   // colour ratio (R-B)/(R+B) in Q1.15, rounded half away from zero
   function automatic int colour_ratio(int unsigned r, int unsigned b);
      longint den, q;
      den = longint'(r) + b;
      if (den == 0) return 0;
      q = ((longint'(absdiff(r, b)) << 15) + den / 2) / den;
      if (r >= b) return q > 32767 ? 32767 : int'(q);
      return -int'(q);
   endfunction

   task automatic model_config(input logic [CSR_IDX_W-1:0] idx, input int unsigned v);
      case (idx)
         CSR_NOISE_THRESHOLD:   thr        = v & 8'hFF;
         CSR_ENTER_COUNT:       enter_lvl  = v & 16'hFFFF;
         CSR_LEAVE_COUNT:       leave_lvl  = v & 16'hFFFF;
         CSR_BUBBLE_MIN_LEVEL:  bub_min    = v & 8'hFF;
         CSR_BUBBLE_MAX_SPREAD: bub_spread = v & 8'hFF;
         CSR_UPDATE_INTERVAL:   upd_every  = v & 16'hFFFF;
         CSR_UPDATE_MAX_NOISE:  upd_noise  = v & 16'hFFFF;
         CSR_UPDATE_ALPHA:      alpha      = v & 9'h1FF;
         default: ;
      endcase
   endtask

   // one accepted pixel; returns 1 with a report at frame end
   task automatic detect_pixel(input logic [23:0] px, input bit last, input bit restart,
                               output bit has_report, output frame_report_t rep);
      int unsigned p, len, s, r, g, b, gray, mx, mn, a, v, count, kind;
      logic [35:0] acc, nv36;
      logic [23:0] nv;
      longint n, mag, q, num, den;
      p = pix_pos;
      has_report = 0;
      rep = '0;
      if (p == 0 && restart) begin
         bg_ready = 0;
         init_seen = 0;
         clear_droplet();
      end
      if (p < ROI) begin
         if (!bg_ready) begin
            acc = (init_seen == 0) ? 36'd0 : acc_mem[p];
            for (int k = 0; k < 3; k++) begin
               s = acc[12*k +: 12] + px[8*k +: 8];
               if (s > 12'hFFF) s = 12'hFFF;
               nv36[12*k +: 12] = s[11:0];
            end
            acc_mem[p] = nv36;
         end else begin
            r = px[7:0];
            g = px[15:8];
            b = px[23:16];
            gray = (77 * absdiff(r, bg_mem[p][7:0]) + 150 * absdiff(g, bg_mem[p][15:8])
                    + 29 * absdiff(b, bg_mem[p][23:16]) + 128) >> 8;
            mx = r; mn = r;
            if (g > mx) mx = g;
            if (b > mx) mx = b;
            if (g < mn) mn = g;
            if (b < mn) mn = b;
            if (gray > thr && !(mn >= bub_min && (mx - mn) <= bub_spread)) begin
               if (fg_cnt < 8191) fg_cnt++;
               red_sum  = (red_sum + r > 20'hFFFFF) ? 20'hFFFFF : red_sum + r;
               blue_sum = (blue_sum + b > 20'hFFFFF) ? 20'hFFFFF : blue_sum + b;
            end
            acc_mem[p] = {12'd0, px};
         end
         pix_pos = p + 1;
      end
      if (!last) return;

      len = p < ROI ? p + 1 : ROI;
      pix_pos = 0;
      count = 0;
      has_report = 1;
      if (!bg_ready) begin
         kind = KIND_INIT;
         init_seen++;
         if (init_seen >= NINIT) begin
            for (int i = 0; i < len; i++) begin
               for (int k = 0; k < 3; k++) begin
                  a = (acc_mem[i][12*k +: 12] + NINIT / 2) / NINIT;
                  if (a > 255) a = 255;
                  nv[8*k +: 8] = a[7:0];
               end
               bg_mem[i] = nv;
            end
            bg_ready = 1;
            init_seen = 0;
            since_upd = 0;
            clear_droplet();
         end
      end else begin
         count = fg_cnt;
         if (since_upd < 65535) since_upd++;
         if (!in_droplet) begin
            kind = KIND_IDLE;
            if (count >= enter_lvl) begin
               in_droplet = 1;
               kind = KIND_SAMPLING;
            end else if (since_upd >= upd_every && count <= upd_noise) begin
               a = alpha > 256 ? 256 : alpha;
               for (int i = 0; i < len; i++) begin
                  for (int k = 0; k < 3; k++) begin
                     v = ((256 - a) * bg_mem[i][8*k +: 8] + a * acc_mem[i][8*k +: 8] + 128) >> 8;
                     nv[8*k +: 8] = v[7:0];
                  end
                  bg_mem[i] = nv;
               end
               since_upd = 0;
               rep.updated = 1;
            end
         end else if (count > leave_lvl) begin
            kind = KIND_SAMPLING;
            if (n_samples < 65535) begin
               v = colour_ratio(red_sum, blue_sum);
               c_sum += int'(v);
               c_sq_sum += longint'(int'(v)) * int'(v);
               n_samples++;
            end
         end else if (n_samples == 0) begin
            kind = KIND_IDLE;
            clear_droplet();
         end else begin
            n = n_samples;
            mag = c_sum < 0 ? -c_sum : c_sum;
            q = (mag + n / 2) / n;
            if (c_sum >= 0) rep.mean = q > 32767 ? 16'sd32767 : 16'(q);
            else rep.mean = q > 32768 ? 16'h8000 : 16'(-q);
            num = n * c_sq_sum - mag * mag;
            den = n * n * 32768;
            if (num > 0) begin
               q = (num + den / 2) / den;
               rep.variance = q > 32767 ? 15'h7FFF : 15'(q);
            end
            rep.frames = 16'(n_samples);
            kind = KIND_REPORT;
            clear_droplet();
         end
      end
      fg_cnt = 0;
      red_sum = 0;
      blue_sum = 0;
      rep.kind = kind[1:0];
      rep.count = count[12:0];
   endtask

   // ---------------- result checking ----------------
   int unsigned rdy_phase = 0;
   int          rdy_mode = 0;

   always @(posedge clock) begin
      rdy_phase <= rdy_phase + 1;
      if (rdy_phase % 50 == 0) rdy_mode <= $urandom_range(0, 2);
      case (rdy_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= $urandom_range(0, 1);
         default: rsp_tready <= (rdy_phase % 16 == 0);
      endcase
   end

   always @(posedge clock) begin
      frame_report_t exp_r, act_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         act_r = '{rsp_tuser, rsp_tdata[12:0], rsp_tdata[28:13], rsp_tdata[44:29],
                   rsp_tdata[59:45], rsp_tdata[60]};
         if (expected_reports.size() == 0) begin
            $display("%0t unexpected word: %p", $time, act_r);
            errors++;
         end else begin
            exp_r = expected_reports.pop_front();
            if (exp_r.kind != act_r.kind) begin
               $display("%0t kind exp %0d got %0d", $time, exp_r.kind, act_r.kind);
               errors++;
            end
            if (exp_r.count != act_r.count) begin
               $display("%0t count exp %0d got %0d", $time, exp_r.count, act_r.count);
               errors++;
            end
            if (exp_r.frames != act_r.frames) begin
               $display("%0t frames exp %0d got %0d", $time, exp_r.frames, act_r.frames);
               errors++;
            end
            if (exp_r.mean != act_r.mean) begin
               $display("%0t mean exp %0d got %0d", $time,
                        $signed(exp_r.mean), $signed(act_r.mean));
               errors++;
            end
            if (exp_r.variance != act_r.variance) begin
               $display("%0t variance exp %0d got %0d", $time,
                        exp_r.variance, act_r.variance);
               errors++;
            end
            if (exp_r.updated != act_r.updated) begin
               $display("%0t updated exp %0d got %0d", $time, exp_r.updated, act_r.updated);
               errors++;
            end
         end
      end
   end

   // ---------------- stimulus ----------------
   int burst_left = 0;
   logic [23:0] base_colour;

   task automatic sender_idle(input int n);
      req_tvalid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // drive one pixel word, wait for it to go, then maybe take a gap
   task automatic send_word(input logic [23:0] px, input bit last, input bit user,
                            input bit typed_init);
      bit has_rep;
      frame_report_t rep;
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      req_tlast  <= last;
      req_tuser  <= user;
      do @(posedge clock); while (!req_tready);
      detect_pixel(px, last, user, has_rep, rep);
      if (has_rep) expected_reports.push_back(typed_init ? frame_report_t'('0) : rep);
      items_sent++;
      if (burst_left == 0) begin
         sender_idle($urandom_range(1, 8));
         burst_left = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 30);
      end else begin
         burst_left--;
      end
   endtask

   task automatic drain();
      sender_idle(1);
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input int unsigned v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v[CSR_DATA_W-1:0];
      @(posedge clock);
      model_config(idx, v);
   endtask

   // block must be drained before this is called
   task automatic pick_settings(input int len);
      int unsigned s [8];
      case ($urandom_range(0, 5))
         4: s = '{0, 0, 0, 0, 255, 1, 65535, 256};
         5: s = '{255, 65535, 65535, 255, 0, 65535, 0, 511};
         default: begin
            s[0] = $urandom_range(0, 60);
            s[1] = $urandom_range(1, len);
            s[2] = $urandom_range(0, s[1]);
            s[3] = $urandom_range(180, 255);
            s[4] = $urandom_range(0, 60);
            s[5] = $urandom_range(1, 5);
            s[6] = $urandom_range(0, len);
            s[7] = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 300);
         end
      endcase
      csr_write(CSR_NOISE_THRESHOLD, s[0]);
      csr_write(CSR_ENTER_COUNT, s[1]);
      csr_write(CSR_LEAVE_COUNT, s[2]);
      csr_write(CSR_BUBBLE_MIN_LEVEL, s[3]);
      csr_write(CSR_BUBBLE_MAX_SPREAD, s[4]);
      csr_write(CSR_UPDATE_INTERVAL, s[5]);
      csr_write(CSR_UPDATE_MAX_NOISE, s[6]);
      csr_write(CSR_UPDATE_ALPHA, s[7]);
      csr_we <= 1'b0;
   endtask

   function automatic logic [23:0] scene_pixel(input scene_type sc);
      logic [23:0] px;
      int c, v;
      if (sc == FR_JUNK) return 24'($urandom);
      if (sc == FR_DROPLET) begin
         c = $urandom_range(0, 7);
         if (c < 6) return 24'($urandom);
         if (c == 6) begin
            v = $urandom_range(215, 255);
            return {8'(v - $urandom_range(0, 10)), 8'(v), 8'(v - $urandom_range(0, 10))};
         end
      end
      for (int k = 0; k < 3; k++) begin
         v = int'(base_colour[8*k +: 8]) + $urandom_range(0, 8) - 4;
         if (v < 0) v = 0;
         if (v > 255) v = 255;
         px[8*k +: 8] = v[7:0];
      end
      return px;
   endfunction

   task automatic send_frame(input int flen, input bit restart, input scene_type sc);
      for (int i = 0; i < flen; i++)
         send_word(scene_pixel(sc), i == flen - 1,
                   (i == 0) ? restart : ($urandom_range(0, 19) == 0), 1'b0);
   endtask

   // restart, build background; if built, runs of clean, junk and droplet scenes
   task automatic run_epoch(input int len, input bit oversize);
      int n_init, n_ready, run;
      base_colour = 24'($urandom);
      n_init = ($urandom_range(0, 5) == 0) ? $urandom_range(1, NINIT - 1) : NINIT;
      for (int f = 0; f < n_init; f++)
         send_frame((oversize && f == 0) ? ROI + 4 : len, f == 0, FR_CLEAN);
      if (n_init < NINIT) return;
      n_ready = $urandom_range(8, 30);
      while (n_ready > 0) begin
         run = $urandom_range(1, 4);
         repeat (run) send_frame(len, 1'b0, ($urandom_range(0, 7) == 0) ? FR_JUNK : FR_CLEAN);
         run = $urandom_range(1, 5);
         repeat (run) send_frame(len, 1'b0, FR_DROPLET);
         n_ready -= 2;
      end
   endtask

   dir_row_t dir_tab [16];

   initial begin
      int ep;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      req_tuser  <= 1'b0;
      csr_we     <= 1'b0;
      csr_index  <= '0;
      csr_wdata  <= '0;
      rsp_tready <= 1'b0;
      thr = RST_NOISE_THRESHOLD; enter_lvl = RST_ENTER_COUNT; leave_lvl = RST_LEAVE_COUNT;
      bub_min = RST_BUBBLE_MIN_LEVEL; bub_spread = RST_BUBBLE_MAX_SPREAD;
      upd_every = RST_UPDATE_INTERVAL; upd_noise = RST_UPDATE_MAX_NOISE;
      alpha = RST_UPDATE_ALPHA;
      pix_pos = 0; init_seen = 0; bg_ready = 0; since_upd = 0;
      fg_cnt = 0; red_sum = 0; blue_sum = 0;
      clear_droplet();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // one-pixel frames: ten to build the background, then extremes against it,
      // then a restart back into averaging
      dir_tab = '{
         '{24'h000000, 1, 1}, '{24'hFFFFFF, 0, 1}, '{24'h0000FF, 0, 1}, '{24'hFF0000, 0, 1},
         '{24'h00FF00, 0, 1}, '{24'h808080, 0, 1}, '{24'h123456, 0, 1}, '{24'hFFFFFF, 0, 1},
         '{24'h000000, 0, 1}, '{24'h7F7F7F, 0, 1},
         '{24'h000000, 0, 0}, '{24'hFFFFFF, 0, 0}, '{24'hF0F0F0, 0, 0}, '{24'h0000FF, 0, 0},
         '{24'hFF0000, 0, 0}, '{24'h55AA55, 1, 1}};
      foreach (dir_tab[i])
         send_word(dir_tab[i].pixel, 1'b1, dir_tab[i].restart, dir_tab[i].init_typed);

      // random epochs, with a settings change at some drained boundaries
      ep = 0;
      while (items_sent < 560) begin
         if (ep == 0 || $urandom_range(0, 2) == 0) begin
            drain();
            pick_settings(8);
         end
         run_epoch($urandom_range(2, 8), 1'b0);
         ep++;
      end

      // oversized first averaging frame, short frames afterwards
      drain();
      pick_settings(16);
      run_epoch(16, 1'b1);

      drain();
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #3000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
`default_nettype wire
